>>> src/tac_pkg.sv
// constants and the arctangent table for the tti anisotropy coefficient pipeline
// used by tti_anisotropy_coefficients; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tac_pkg;
  localparam int CordicSteps = 24;
  localparam int XyW = 33;
  localparam int ZW = 28;
  localparam logic signed [XyW-1:0] CordicGain = 33'sd652032874;
  localparam logic signed [ZW-1:0] HalfPi = 28'sd26353589;
  localparam logic signed [ZW-1:0] Pi = 28'sd52707179;
  localparam logic signed [63:0] DirLimit = 64'sd16384;
  localparam logic signed [63:0] VsqMax = 64'sd1073741823;

  typedef logic signed [XyW-1:0] xy_t;
  typedef logic signed [ZW-1:0] z_t;

  function automatic z_t atan_val(input int idx);
    z_t r;
    case (idx)
      0: r = 28'sd13176795;
      1: r = 28'sd7778716;
      2: r = 28'sd4110060;
      3: r = 28'sd2086331;
      4: r = 28'sd1047214;
      5: r = 28'sd524117;
      6: r = 28'sd262123;
      7: r = 28'sd131069;
      default: r = z_t'(28'sd1 <<< (24 - idx));
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> src/tti_anisotropy_coefficients.sv
// direction-cosine products and scaled velocity squares for one tti grid point
// depends on tac_pkg
// throughput: one transaction per cycle; the whole pipeline advances unless the output is stalled
// the two angles each go through a 24-stage unrolled cordic, then two multiply stages
// reset clears the valid bits only; data registers are left as they are
`timescale 1ns / 1ps
`default_nettype none
module tti_anisotropy_coefficients (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [13:0] p_velocity,
  input  wire logic [13:0] s_velocity,
  input  wire logic signed [15:0] thomsen_epsilon,
  input  wire logic signed [15:0] thomsen_delta,
  input  wire logic signed [15:0] tilt_angle,
  input  wire logic signed [15:0] azimuth_angle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] dir_xx,
  output logic signed [15:0] dir_yy,
  output logic signed [15:0] dir_zz,
  output logic signed [15:0] dir_xy,
  output logic signed [15:0] dir_yz,
  output logic signed [15:0] dir_xz,
  output logic [27:0]      p_vert_sq,
  output logic [29:0]      p_horiz_sq,
  output logic [27:0]      s_vert_sq,
  output logic [29:0]      p_nmo_sq
);
  import tac_pkg::*;

  logic en;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  // cordic pipeline, index 0 is the fold stage
  xy_t tx [0:CordicSteps];
  xy_t ty [0:CordicSteps];
  z_t  tz [0:CordicSteps];
  logic tf [0:CordicSteps];
  xy_t ax [0:CordicSteps];
  xy_t ay [0:CordicSteps];
  z_t  az [0:CordicSteps];
  logic af [0:CordicSteps];
  logic vld [0:CordicSteps];
  logic [27:0] vp2 [0:CordicSteps];
  logic [27:0] vs2 [0:CordicSteps];
  logic signed [15:0] eps [0:CordicSteps];
  logic signed [15:0] dlt [0:CordicSteps];

  z_t tz_raw, az_raw;
  assign tz_raw = z_t'({{(ZW-27){tilt_angle[15]}}, tilt_angle, 11'b0});
  assign az_raw = z_t'({{(ZW-27){azimuth_angle[15]}}, azimuth_angle, 11'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx[0] <= CordicGain;
      ty[0] <= '0;
      ax[0] <= CordicGain;
      ay[0] <= '0;
      // fold angles beyond a quarter turn, negating the cosine
      if (tz_raw > HalfPi) begin
        tz[0] <= Pi - tz_raw;
        tf[0] <= 1'b1;
      end else if (tz_raw < -HalfPi) begin
        tz[0] <= -Pi - tz_raw;
        tf[0] <= 1'b1;
      end else begin
        tz[0] <= tz_raw;
        tf[0] <= 1'b0;
      end
      if (az_raw > HalfPi) begin
        az[0] <= Pi - az_raw;
        af[0] <= 1'b1;
      end else if (az_raw < -HalfPi) begin
        az[0] <= -Pi - az_raw;
        af[0] <= 1'b1;
      end else begin
        az[0] <= az_raw;
        af[0] <= 1'b0;
      end
      vp2[0] <= 28'(p_velocity) * 28'(p_velocity);
      vs2[0] <= 28'(s_velocity) * 28'(s_velocity);
      eps[0] <= thomsen_epsilon;
      dlt[0] <= thomsen_delta;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (tz[i] >= 0) begin
          tx[i+1] <= tx[i] - (ty[i] >>> i);
          ty[i+1] <= ty[i] + (tx[i] >>> i);
          tz[i+1] <= tz[i] - atan_val(i);
        end else begin
          tx[i+1] <= tx[i] + (ty[i] >>> i);
          ty[i+1] <= ty[i] - (tx[i] >>> i);
          tz[i+1] <= tz[i] + atan_val(i);
        end
        if (az[i] >= 0) begin
          ax[i+1] <= ax[i] - (ay[i] >>> i);
          ay[i+1] <= ay[i] + (ax[i] >>> i);
          az[i+1] <= az[i] - atan_val(i);
        end else begin
          ax[i+1] <= ax[i] + (ay[i] >>> i);
          ay[i+1] <= ay[i] - (ax[i] >>> i);
          az[i+1] <= az[i] + atan_val(i);
        end
        tf[i+1] <= tf[i];
        af[i+1] <= af[i];
        vp2[i+1] <= vp2[i];
        vs2[i+1] <= vs2[i];
        eps[i+1] <= eps[i];
        dlt[i+1] <= dlt[i];
      end
    end
  end

  // first multiply stage: squares, double-angle products and the epsilon and delta products of the p velocity square
  xy_t st, ct, sp, cp;
  assign st = ty[CordicSteps];
  assign ct = tf[CordicSteps] ? -tx[CordicSteps] : tx[CordicSteps];
  assign sp = ay[CordicSteps];
  assign cp = af[CordicSteps] ? -ax[CordicSteps] : ax[CordicSteps];

  localparam logic signed [67:0] Half30 = 68'sd1 <<< 29;
  logic signed [67:0] p_st2, p_ct2, p_sp2, p_cp2, p_s2t, p_s2p;
  logic signed [17:0] f_eps, f_dlt;
  always_comb begin
    p_st2 = ((68'(st) * 68'(st)) + Half30) >>> 30;
    p_ct2 = ((68'(ct) * 68'(ct)) + Half30) >>> 30;
    p_sp2 = ((68'(sp) * 68'(sp)) + Half30) >>> 30;
    p_cp2 = ((68'(cp) * 68'(cp)) + Half30) >>> 30;
    p_s2t = (((68'(st) * 68'(ct)) <<< 1) + Half30) >>> 30;
    p_s2p = (((68'(sp) * 68'(cp)) <<< 1) + Half30) >>> 30;
    f_eps = 18'sd16384 + (18'(eps[CordicSteps]) <<< 1);
    f_dlt = 18'sd16384 + (18'(dlt[CordicSteps]) <<< 1);
  end

  logic m1_vld;
  logic signed [32:0] st2, ct2, sp2, cp2, s2t, s2p, sp1, cp1;
  logic signed [47:0] ph_raw, pn_raw;
  logic [27:0] vp2_m1, vs2_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else if (en) begin
      m1_vld <= vld[CordicSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2 <= p_st2[32:0];
      ct2 <= p_ct2[32:0];
      sp2 <= p_sp2[32:0];
      cp2 <= p_cp2[32:0];
      s2t <= p_s2t[32:0];
      s2p <= p_s2p[32:0];
      sp1 <= sp;
      cp1 <= cp;
      ph_raw <= 48'($signed({1'b0, vp2[CordicSteps]})) * 48'(f_eps);
      pn_raw <= 48'($signed({1'b0, vp2[CordicSteps]})) * 48'(f_dlt);
      vp2_m1 <= vp2[CordicSteps];
      vs2_m1 <= vs2[CordicSteps];
    end
  end

  // second multiply stage
  logic m2_vld;
  logic signed [65:0] q_xx, q_yy, q_xy, q_yz, q_xz;
  logic signed [32:0] ct2_m2;
  logic signed [47:0] ph_r, pn_r;
  logic [27:0] vp2_m2, vs2_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else if (en) begin
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_xx <= 66'(st2) * 66'(cp2);
      q_yy <= 66'(st2) * 66'(sp2);
      q_xy <= 66'(st2) * 66'(s2p);
      q_yz <= 66'(s2t) * 66'(sp1);
      q_xz <= 66'(s2t) * 66'(cp1);
      ct2_m2 <= ct2;
      ph_r <= (ph_raw + 48'sd8192) >>> 14;
      pn_r <= (pn_raw + 48'sd8192) >>> 14;
      vp2_m2 <= vp2_m1;
      vs2_m2 <= vs2_m1;
    end
  end

  function automatic logic signed [15:0] dir_round(input logic signed [65:0] v, input int sh);
    logic signed [65:0] r;
    logic signed [63:0] w;
    r = (v + (66'sd1 <<< (sh - 1))) >>> sh;
    w = r[63:0];
    if (w > DirLimit) w = DirLimit;
    if (w < -DirLimit) w = -DirLimit;
    return w[15:0];
  endfunction

  function automatic logic [29:0] vsq_sat(input logic signed [47:0] v);
    logic [29:0] r;
    if (v < 0) r = '0;
    else if (64'(v) > VsqMax) r = '1;
    else r = v[29:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_xx <= dir_round(q_xx, 46);
      dir_yy <= dir_round(q_yy, 46);
      dir_zz <= dir_round(66'(ct2_m2), 16);
      dir_xy <= dir_round(q_xy, 46);
      dir_yz <= dir_round(q_yz, 46);
      dir_xz <= dir_round(q_xz, 46);
      p_vert_sq <= vp2_m2;
      s_vert_sq <= vs2_m2;
      p_horiz_sq <= vsq_sat(ph_r);
      p_nmo_sq <= vsq_sat(pn_r);
    end
  end

  a_stall_back : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output stalled");
  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");
  a_zz_sign : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !dir_zz[15])
    else $error("negative cos squared");
endmodule
`default_nettype wire
